// ===== rtl/core/uart_sensor_frame_parser_core_assert.svh =====
// assertion macros used by the checker file usfp_checker.sv
// clk and rst_n must be visible where a macro is used
`ifndef UART_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH
`define UART_SENSOR_FRAME_PARSER_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define USFP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define USFP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/usfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package usfp_pkg;

    localparam int PAYLOAD_BYTES = 12;
    localparam int CNT_W         = $clog2(PAYLOAD_BYTES);
    localparam int CFG_ADDR_W    = 8;

    // parser phases
    localparam logic [2:0] PH_HUNT  = 3'd0;
    localparam logic [2:0] PH_ADDR  = 3'd1;
    localparam logic [2:0] PH_LEN   = 3'd2;
    localparam logic [2:0] PH_IDENT = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_END   = 3'd5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_START_MARKER = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_END_MARKER   = CFG_ADDR_W'(1);

    localparam logic [7:0] START_MARKER_RST = 8'hAA;
    localparam logic [7:0] END_MARKER_RST   = 8'h55;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        byte_t       frame_address;
        byte_t       frame_ident;
        logic [31:0] temperature_bits;
        logic [31:0] humidity_bits;
        logic [15:0] pressure_value;
        byte_t       status_flag;
    } frame_t;

    typedef struct packed {
        byte_t start_marker;
        byte_t end_marker;
    } markers_t;

endpackage
`default_nettype wire

// ===== rtl/core/usfp_ifs.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface usfp_byte_if;
    import usfp_pkg::*;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface usfp_frame_if;
    import usfp_pkg::*;
    logic        valid;
    logic        ready;
    byte_t       frame_address;
    byte_t       frame_ident;
    logic [31:0] temperature_bits;
    logic [31:0] humidity_bits;
    logic [15:0] pressure_value;
    byte_t       status_flag;

    modport source (output valid, output frame_address, output frame_ident,
                    output temperature_bits, output humidity_bits,
                    output pressure_value, output status_flag, input ready);
    modport sink   (input valid, input frame_address, input frame_ident,
                    input temperature_bits, input humidity_bits,
                    input pressure_value, input status_flag, output ready);
endinterface

interface usfp_cfg_if;
    import usfp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    byte_t                 data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/usfp_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none
module usfp_parser (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    input  wire usfp_pkg::byte_t   rx_byte,
    input  wire usfp_pkg::markers_t markers,
    output logic                   frame_hit,
    output usfp_pkg::frame_t       frame
);
    import usfp_pkg::*;

    localparam logic [CNT_W-1:0] PAYLOAD_CNT = CNT_W'(PAYLOAD_BYTES);
    localparam byte_t            LEN_BYTE    = 8'(PAYLOAD_BYTES);

    logic [2:0]       phase_reg, phase_next;
    byte_t            addr_reg, addr_next;
    byte_t            ident_reg, ident_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             store_we;
    byte_t            store_reg [PAYLOAD_BYTES];

    always_comb
    begin
        phase_next = phase_reg;
        addr_next  = addr_reg;
        ident_next = ident_reg;
        count_next = count_reg;
        store_we   = 1'b0;
        frame_hit  = 1'b0;
        if (byte_valid)
        begin
            case (phase_reg)
                PH_HUNT:
                begin
                    if (rx_byte == markers.start_marker)
                        phase_next = PH_ADDR;
                end
                PH_ADDR:
                begin
                    addr_next  = rx_byte;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    // a bad length is dropped, not rechecked as a start byte
                    phase_next = (rx_byte == LEN_BYTE) ? PH_IDENT : PH_HUNT;
                end
                PH_IDENT:
                begin
                    ident_next = rx_byte;
                    count_next = '0;
                    phase_next = PH_DATA;
                end
                PH_DATA:
                begin
                    if (count_reg < PAYLOAD_CNT)
                    begin
                        store_we   = 1'b1;
                        count_next = count_reg + 1'b1;
                        if (count_next >= PAYLOAD_CNT)
                            phase_next = PH_END;
                    end
                    else
                        phase_next = PH_END;
                end
                PH_END:
                begin
                    frame_hit  = (rx_byte == markers.end_marker);
                    phase_next = PH_HUNT;
                end
                default:
                    phase_next = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            addr_reg  <= '0;
            ident_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            addr_reg  <= addr_next;
            ident_reg <= ident_next;
            count_reg <= count_next;
        end
    end

    // every entry is written before the end phase is reached
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[count_reg] <= rx_byte;
    end

    always_comb
    begin
        frame.frame_address    = addr_reg;
        frame.frame_ident      = ident_reg;
        frame.temperature_bits = {store_reg[3], store_reg[2], store_reg[1], store_reg[0]};
        frame.humidity_bits    = {store_reg[7], store_reg[6], store_reg[5], store_reg[4]};
        frame.pressure_value   = {store_reg[9], store_reg[8]};
        frame.status_flag      = store_reg[10];
    end

endmodule
`default_nettype wire

// ===== rtl/core/uart_sensor_frame_parser_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | role   | payload                                   | moves when
// rx      | sink   | rx_byte                                   | rx.valid & rx.ready
// frame   | source | address, ident, temp, humidity, press, flag | frame.valid & frame.ready
// cfg     | sink   | addr (register index), data               | cfg.valid & cfg.ready
//
// a byte is taken every cycle rx.ready is high; parser state updates on the same edge
// a decoded frame appears in the output register the cycle after its end byte
// rx.ready drops only while a frame waits in the output register and is not taken
// cfg.ready is always high; reset is asynchronous, active low, markers 0xAA and 0x55
module uart_sensor_frame_parser_core (
    input  wire logic clk,
    input  wire logic rst_n,
    usfp_byte_if.sink    rx,
    usfp_frame_if.source frame,
    usfp_cfg_if.sink     cfg
);
    import usfp_pkg::*;

    markers_t markers_reg, markers_next;
    logic     out_valid_reg, out_valid_next;
    frame_t   out_data_reg;
    logic     rx_accept;
    logic     frame_hit;
    frame_t   frame_dec;

    assign rx.ready  = !out_valid_reg || frame.ready;
    assign rx_accept = rx.valid && rx.ready;
    assign cfg.ready = 1'b1;

    always_comb
    begin
        markers_next = markers_reg;
        if (cfg.valid)
        begin
            case (cfg.addr)
                REG_START_MARKER: markers_next.start_marker = cfg.data;
                REG_END_MARKER:   markers_next.end_marker   = cfg.data;
                default:          markers_next = markers_reg;
            endcase
        end
    end

    usfp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (rx_accept),
        .rx_byte    (rx.rx_byte),
        .markers    (markers_reg),
        .frame_hit  (frame_hit),
        .frame      (frame_dec)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (frame_hit)
            out_valid_next = 1'b1;
        else if (frame.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            markers_reg.start_marker <= START_MARKER_RST;
            markers_reg.end_marker   <= END_MARKER_RST;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            markers_reg   <= markers_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (frame_hit)
            out_data_reg <= frame_dec;
    end

    assign frame.valid            = out_valid_reg;
    assign frame.frame_address    = out_data_reg.frame_address;
    assign frame.frame_ident      = out_data_reg.frame_ident;
    assign frame.temperature_bits = out_data_reg.temperature_bits;
    assign frame.humidity_bits    = out_data_reg.humidity_bits;
    assign frame.pressure_value   = out_data_reg.pressure_value;
    assign frame.status_flag      = out_data_reg.status_flag;

endmodule
`default_nettype wire

// ===== rtl/core/usfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "uart_sensor_frame_parser_core_assert.svh"
module usfp_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        rx_valid,
    input wire logic        rx_ready,
    input wire logic        frame_valid,
    input wire logic        frame_ready,
    input wire logic [7:0]  frame_address,
    input wire logic [31:0] temperature_bits
);

    // a stalled frame keeps its valid and payload
    `USFP_ASSERT_NXT(a_frame_hold, frame_valid && !frame_ready,
        frame_valid && $stable(frame_address) && $stable(temperature_bits),
        "frame changed while stalled")

    // input backpressure only comes from a waiting, untaken frame
    `USFP_ASSERT_IMP(a_rx_stall, !rx_ready, frame_valid && !frame_ready,
        "rx stalled without a blocked frame")

    // a new frame always follows an accepted input byte
    `USFP_ASSERT_IMP(a_frame_src, $rose(frame_valid), $past(rx_valid && rx_ready),
        "frame appeared without an input item")

endmodule

bind uart_sensor_frame_parser_core usfp_checker u_usfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_valid         (rx.valid),
    .rx_ready         (rx.ready),
    .frame_valid      (frame.valid),
    .frame_ready      (frame.ready),
    .frame_address    (frame.frame_address),
    .temperature_bits (frame.temperature_bits)
);
`default_nettype wire

// ===== verif/usfp_frame_checker.sv =====
`timescale 1ns / 1ps
module usfp_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    usfp_byte_if        rx,
    usfp_frame_if       frame,
    usfp_cfg_if         cfg,
    output int unsigned frames_due,
    output int unsigned fail_count
);
    import usfp_pkg::*;

    // parser shadow state
    logic [2:0] cur_phase;
    byte_t      addr_hold;
    byte_t      ident_hold;
    logic [3:0] data_count;
    byte_t      data_bytes [PAYLOAD_BYTES];
    byte_t      sof_value;
    byte_t      eof_value;

    frame_t      pending_frames [$];
    int unsigned mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task automatic check_frame();
        frame_t want;
        if (pending_frames.size() == 0)
        begin
            report_mismatch($sformatf("frame with address %0h ident %0h not expected",
                                      frame.frame_address, frame.frame_ident));
            return;
        end
        want = pending_frames.pop_front();
        check_field("frame_address", frame.frame_address, want.frame_address);
        check_field("frame_ident", frame.frame_ident, want.frame_ident);
        check_field("temperature_bits", frame.temperature_bits, want.temperature_bits);
        check_field("humidity_bits", frame.humidity_bits, want.humidity_bits);
        check_field("pressure_value", frame.pressure_value, want.pressure_value);
        check_field("status_flag", frame.status_flag, want.status_flag);
    endtask

    task automatic decode_rx_byte(input byte_t b);
        frame_t got_frame;
        case (cur_phase)
            PH_HUNT:
                if (b == sof_value)
                    cur_phase = PH_ADDR;
            PH_ADDR:
            begin
                addr_hold = b;
                cur_phase = PH_LEN;
            end
            // a bad length byte is swallowed, never taken as a start byte
            PH_LEN:
                cur_phase = (b == PAYLOAD_BYTES) ? PH_IDENT : PH_HUNT;
            PH_IDENT:
            begin
                ident_hold = b;
                data_count = '0;
                foreach (data_bytes[i])
                    data_bytes[i] = '0;
                cur_phase = PH_DATA;
            end
            PH_DATA:
                if (data_count < PAYLOAD_BYTES)
                begin
                    data_bytes[data_count] = b;
                    data_count = data_count + 4'd1;
                    if (data_count >= PAYLOAD_BYTES)
                        cur_phase = PH_END;
                end
                else
                    cur_phase = PH_END;
            PH_END:
            begin
                if (b == eof_value)
                begin
                    got_frame.frame_address    = addr_hold;
                    got_frame.frame_ident      = ident_hold;
                    got_frame.temperature_bits = {data_bytes[3], data_bytes[2],
                                                  data_bytes[1], data_bytes[0]};
                    got_frame.humidity_bits    = {data_bytes[7], data_bytes[6],
                                                  data_bytes[5], data_bytes[4]};
                    got_frame.pressure_value   = {data_bytes[9], data_bytes[8]};
                    got_frame.status_flag      = data_bytes[10];
                    pending_frames.push_back(got_frame);
                end
                cur_phase = PH_HUNT;
            end
            default:
                cur_phase = PH_HUNT;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_phase  = PH_HUNT;
            addr_hold  = '0;
            ident_hold = '0;
            data_count = '0;
            foreach (data_bytes[i])
                data_bytes[i] = '0;
            sof_value  = START_MARKER_RST;
            eof_value  = END_MARKER_RST;
            pending_frames.delete();
            mismatches = 0;
            frames_due <= 0;
            fail_count <= 0;
        end
        else
        begin
            if (frame.valid && frame.ready)
                check_frame();
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.addr == REG_START_MARKER)
                    sof_value = cfg.data;
                else if (cfg.addr == REG_END_MARKER)
                    eof_value = cfg.data;
            end
            if (rx.valid && rx.ready)
                decode_rx_byte(rx.rx_byte);
            frames_due <= pending_frames.size();
            fail_count <= mismatches;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import usfp_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int FILL_RANDOM  = 0;
    localparam int FILL_ZERO    = 1;
    localparam int FILL_ONES    = 2;
    localparam int FILL_MARKERS = 3;
    localparam int IDLE_NONE    = 0;
    localparam int IDLE_FULL    = 1;
    localparam int IDLE_SPARSE  = 2;

    logic clk;
    logic rst_n;

    usfp_byte_if  rx_if ();
    usfp_frame_if frame_if ();
    usfp_cfg_if   cfg_if ();

    int unsigned frames_due;
    int unsigned fail_count;

    // markers as last written, used to build frames
    byte_t       cur_sof;
    byte_t       cur_eof;
    int          send_mode;
    int          recv_mode;
    int unsigned bytes_sent;
    int unsigned idle_cycles;

    uart_sensor_frame_parser_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .frame (frame_if),
        .cfg   (cfg_if)
    );

    usfp_frame_checker chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx_if),
        .frame      (frame_if),
        .cfg        (cfg_if),
        .frames_due (frames_due),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic int draw_wait(input int mode);
        case (mode)
            IDLE_NONE: return 0;
            IDLE_FULL: return $urandom_range(0, 13);
            default:   return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 13) : 0;
        endcase
    endfunction

    function automatic byte_t payload_byte(input int fill);
        case (fill)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hFF;
            FILL_MARKERS:
                case ($urandom_range(0, 3))
                    0:       return cur_sof;
                    1:       return cur_eof;
                    2:       return 8'(PAYLOAD_BYTES);
                    default: return 8'($urandom);
                endcase
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic push_byte(input byte_t b);
        int gap;
        gap = draw_wait(send_mode);
        if (gap > 0)
        begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do
            @(posedge clk);
        while (!rx_if.ready);
        bytes_sent++;
    endtask

    // a bad length ends the frame right there
    task automatic push_frame(input byte_t addr, input byte_t ident, input byte_t len_byte,
                              input byte_t eof_byte, input int fill);
        push_byte(cur_sof);
        push_byte(addr);
        push_byte(len_byte);
        if (len_byte == PAYLOAD_BYTES)
        begin
            push_byte(ident);
            for (int i = 0; i < PAYLOAD_BYTES; i++)
                push_byte(payload_byte(fill));
            push_byte(eof_byte);
        end
    endtask

    // sender holds off until every decoded frame has been taken
    task automatic drain_results();
        rx_if.valid <= 1'b0;
        @(posedge clk);
        while (frames_due != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input byte_t val);
        cfg_if.valid <= 1'b1;
        cfg_if.addr  <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == REG_START_MARKER)
            cur_sof = val;
        else if (idx == REG_END_MARKER)
            cur_eof = val;
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_traffic(input int unsigned quota);
        int unsigned stop_at;
        int          kind;
        byte_t       v;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(0, 15) == 0)
            begin
                send_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
                recv_mode = $urandom_range(IDLE_NONE, IDLE_SPARSE);
            end
            if ($urandom_range(0, 24) == 0)
                drain_results();
            kind = $urandom_range(0, 9);
            if (kind < 7)
                push_frame(8'($urandom), 8'($urandom), 8'(PAYLOAD_BYTES), cur_eof,
                           ($urandom_range(0, 3) == 0) ?
                           $urandom_range(FILL_ZERO, FILL_MARKERS) : FILL_RANDOM);
            else if (kind == 7)
            begin
                if (cur_sof != PAYLOAD_BYTES && $urandom_range(0, 2) == 0)
                    v = cur_sof;
                else
                    do
                        v = 8'($urandom);
                    while (v == PAYLOAD_BYTES);
                push_frame(8'($urandom), 8'($urandom), v, cur_eof, FILL_RANDOM);
            end
            else if (kind == 8)
            begin
                if (cur_sof != cur_eof && $urandom_range(0, 2) == 0)
                    v = cur_sof;
                else
                    do
                        v = 8'($urandom);
                    while (v == cur_eof);
                push_frame(8'($urandom), 8'($urandom), 8'(PAYLOAD_BYTES), v, FILL_RANDOM);
            end
            else
                repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        end
    endtask

    // result side: random stall before each item
    initial
    begin
        int stall;
        frame_if.ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            stall = draw_wait(recv_mode);
            if (stall > 0)
            begin
                frame_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            frame_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!frame_if.valid);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((rx_if.valid && rx_if.ready) || (frame_if.valid && frame_if.ready)
                 || (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        byte_t sof_next;
        byte_t eof_next;
        rst_n          <= 1'b0;
        rx_if.valid    <= 1'b0;
        rx_if.rx_byte  <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.addr    <= '0;
        cfg_if.data    <= '0;
        cur_sof        = START_MARKER_RST;
        cur_eof        = END_MARKER_RST;
        send_mode      = IDLE_NONE;
        recv_mode      = IDLE_NONE;
        bytes_sent     = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes at the reset markers, back to back
        push_frame(8'h00, 8'hFF, 8'(PAYLOAD_BYTES), cur_eof, FILL_ONES);
        // length byte equal to the start byte must not reopen a frame
        push_frame(8'h33, 8'h00, cur_sof, cur_eof, FILL_ZERO);
        push_byte(8'h12);
        push_byte(8'(PAYLOAD_BYTES));
        // wrong end byte that looks like a start byte
        push_frame(8'h5A, 8'hA5, 8'(PAYLOAD_BYTES), cur_sof, FILL_MARKERS);

        send_mode = IDLE_SPARSE;
        recv_mode = IDLE_SPARSE;
        run_traffic(100);

        for (int p = 1; p < 7; p++)
        begin
            drain_results();
            case (p)
                1:
                begin
                    sof_next = 8'h00;
                    eof_next = 8'hFF;
                end
                2:
                begin
                    sof_next = 8'hFF;
                    eof_next = 8'h00;
                end
                3:
                begin
                    sof_next = 8'($urandom);
                    eof_next = sof_next;
                end
                4:
                begin
                    sof_next = 8'(PAYLOAD_BYTES);
                    eof_next = 8'($urandom);
                end
                default:
                begin
                    sof_next = 8'($urandom);
                    eof_next = 8'($urandom);
                end
            endcase
            write_reg(REG_START_MARKER, sof_next);
            write_reg(REG_END_MARKER, eof_next);
            // writes to an unmapped index must be dropped
            if (p == 1 || p == 5)
                write_reg(CFG_ADDR_W'($urandom_range(REG_END_MARKER + 1, 255)),
                          8'($urandom));
            run_traffic(140);
        end

        drain_results();
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== uart_sensor_frame_parser_core.f =====
+incdir+rtl/core
rtl/core/usfp_pkg.sv
rtl/core/usfp_ifs.sv
rtl/core/usfp_parser.sv
rtl/core/uart_sensor_frame_parser_core.sv
rtl/core/usfp_checker.sv
verif/usfp_frame_checker.sv
verif/tb_top.sv
